// ===== hw/rtl/plcr_pkg.sv =====
package plcr_pkg;

    localparam int CHANNEL_BITS = 16;
    localparam int NUM_STOPS    = 9;
    localparam int POS_W        = 17;
    localparam int MIX_W        = 16;
    localparam int NUM_CHAN     = 4;
    localparam int DIV_STEPS    = 16;
    localparam int ADDR_W       = 6;

    localparam logic [POS_W-1:0] POS_HALF = 17'h08000;
    localparam logic [POS_W-1:0] POS_ONE  = 17'h10000;

    localparam logic [ADDR_W-4:0] REG_SUNRISE   = 3'd0;
    localparam logic [ADDR_W-4:0] REG_DAY_LOW   = 3'd1;
    localparam logic [ADDR_W-4:0] REG_DAY_HIGH  = 3'd2;
    localparam logic [ADDR_W-4:0] REG_SUNSET    = 3'd3;
    localparam logic [ADDR_W-4:0] REG_NIGHT_LOW = 3'd4;
    localparam logic [ADDR_W-4:0] REG_NIGHT_HI  = 3'd5;
    localparam logic [ADDR_W-4:0] REG_DAY_POS   = 3'd6;
    localparam logic [ADDR_W-4:0] REG_NIGHT_POS = 3'd7;

    localparam logic [31:0] DAY_POS_RST   = 32'h7000_1000;
    localparam logic [31:0] NIGHT_POS_RST = 32'hF000_9000;

    // payload handed from one divider cell to the next
    typedef struct packed {
        logic                    vld;
        logic                    flat;   // output endpoint color a unchanged
        logic [POS_W-1:0]        rem;
        logic [POS_W-1:0]        den;
        logic [MIX_W-1:0]        quo;
        logic [63:0]             col_a;
        logic [63:0]             col_b;
    } t_cell;

endpackage

// ===== hw/rtl/piecewise_linear_color_ramp_unit.sv =====
// Channel | Dir | Fields (low bit first)
// s_axis  | in  | tdata[16:0] sample_pos, zero filled to 24 bits
// m_axis  | out | tdata chan_red, chan_green, chan_blue, chan_alpha
// apb     | in  | 8 registers at 8*i, 64-bit data
// One item per cycle; pipeline stages in order: stop search register, 16 divider
// cells (one quotient bit each), the product stage and the output register.
// Reset is synchronous; it clears valid bits and color registers and loads the position defaults.
// The whole pipe advances when the output register is empty or taken;
// a stall at m_axis_tready holds every stage.
module piecewise_linear_color_ramp_unit
    import plcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // sample_pos [16:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // red, green, blue, alpha
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    localparam int LAT = DIV_STEPS + 3;

    logic [63:0] r_col [6];
    logic [31:0] r_day_pos;
    logic [31:0] r_night_pos;
    logic        w_en;
    logic [LAT-2:0] r_vld_tail;

    assign pready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_col[i] <= '0;
            r_day_pos   <= DAY_POS_RST;
            r_night_pos <= NIGHT_POS_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[ADDR_W-1:3])
                REG_DAY_POS:   r_day_pos   <= pwdata[31:0];
                REG_NIGHT_POS: r_night_pos <= pwdata[31:0];
                REG_SUNRISE, REG_DAY_LOW, REG_DAY_HIGH, REG_SUNSET,
                REG_NIGHT_LOW, REG_NIGHT_HI:
                    r_col[paddr[ADDR_W-1:3]] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:3])
            REG_DAY_POS:   prdata = {32'd0, r_day_pos};
            REG_NIGHT_POS: prdata = {32'd0, r_night_pos};
            default:       prdata = r_col[paddr[ADDR_W-1:3]];
        endcase
    end

    // stop table
    logic [POS_W-1:0] w_pos [NUM_STOPS];
    logic [63:0]      w_col [NUM_STOPS];
    always_comb begin
        w_pos[0] = '0;
        w_pos[1] = {1'b0, r_day_pos[15:0]};
        w_pos[2] = POS_W'(({1'b0, r_day_pos[15:0]} + {1'b0, r_day_pos[31:16]}) >> 1);
        w_pos[3] = {1'b0, r_day_pos[31:16]};
        w_pos[4] = POS_HALF;
        w_pos[5] = {1'b0, r_night_pos[15:0]};
        w_pos[6] = POS_W'(({1'b0, r_night_pos[15:0]} + {1'b0, r_night_pos[31:16]}) >> 1);
        w_pos[7] = {1'b0, r_night_pos[31:16]};
        w_pos[8] = POS_ONE;
        w_col[0] = r_col[0]; w_col[1] = r_col[1]; w_col[2] = r_col[2];
        w_col[3] = r_col[1]; w_col[4] = r_col[3]; w_col[5] = r_col[4];
        w_col[6] = r_col[5]; w_col[7] = r_col[4]; w_col[8] = r_col[0];
    end

    // first stop above t, priority search over independent compares
    logic [POS_W-1:0] w_t;
    t_cell            w_head;
    logic             w_found;
    assign w_t = s_axis_tdata[POS_W-1:0];
    always_comb begin
        w_found      = 1'b0;
        w_head.vld   = s_axis_tvalid;
        w_head.flat  = 1'b1;
        w_head.rem   = '0;
        w_head.den   = POS_W'(1);
        w_head.quo   = '0;
        w_head.col_a = r_col[0];
        w_head.col_b = r_col[0];
        for (int k = 1; k < NUM_STOPS; k++) begin
            if (!w_found && w_pos[k] > w_t) begin
                w_found = 1'b1;
                if (w_t >= w_pos[k-1]) begin
                    w_head.flat  = 1'b0;
                    w_head.rem   = w_t - w_pos[k-1];
                    w_head.den   = w_pos[k] - w_pos[k-1];
                    w_head.col_a = w_col[k-1];
                    w_head.col_b = w_col[k];
                end else begin
                    // mix forced to zero: blend of a alone
                    w_head.flat  = 1'b1;
                    w_head.col_a = w_col[k-1];
                end
            end
        end
    end

    // pipeline enable: advance when output slot free or being taken
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    t_cell w_chain [DIV_STEPS+1];
    t_cell r_in;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in.vld <= 1'b0;
        else if (w_en) r_in.vld <= w_head.vld;
        if (w_en) begin
            r_in.flat <= w_head.flat; r_in.rem <= w_head.rem; r_in.den <= w_head.den;
            r_in.quo <= w_head.quo; r_in.col_a <= w_head.col_a; r_in.col_b <= w_head.col_b;
        end
    end
    assign w_chain[0] = r_in;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        plcr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    t_cell w_last;
    assign w_last = w_chain[DIV_STEPS];

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
        plcr_blend u_blend (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_a    (w_last.col_a[16*c +: CHANNEL_BITS]),
            .i_b    (w_last.col_b[16*c +: CHANNEL_BITS]),
            .i_mix  (w_last.flat ? '0 : w_last.quo),
            .i_flat (w_last.flat),
            .o_chan (m_axis_tdata[16*c +: CHANNEL_BITS])
        );
        if (CHANNEL_BITS < 16) begin : g_pad
            assign m_axis_tdata[16*c+CHANNEL_BITS +: 16-CHANNEL_BITS] = '0;
        end
    end

    // valid for the product stage and output register
    logic [1:0] r_out_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= '0;
        else if (w_en) r_out_vld <= {r_out_vld[0], w_last.vld};
    end
    assign m_axis_tvalid = r_out_vld[1];

    // shift register of input valid bits, for checking only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld_tail <= '0;
        else if (w_en) r_vld_tail <= {r_vld_tail[LAT-3:0], s_axis_tvalid};
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed during stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld[0] == r_vld_tail[LAT-2] || !$past(i_rst_n))
        else $error("valid lost in pipe");

endmodule

// ===== hw/rtl/plcr_div_cell.sv =====
module plcr_div_cell
    import plcr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);

    t_cell r_cell;
    t_cell n_cell;
    logic [POS_W:0] w_dbl;

    // one restoring division step: shift remainder, try subtract
    assign w_dbl = {i_cell.rem, 1'b0};

    always_comb begin
        n_cell = i_cell;
        if (w_dbl >= {1'b0, i_cell.den}) begin
            n_cell.rem = POS_W'(w_dbl - {1'b0, i_cell.den});
            n_cell.quo = {i_cell.quo[MIX_W-2:0], 1'b1};
        end else begin
            n_cell.rem = w_dbl[POS_W-1:0];
            n_cell.quo = {i_cell.quo[MIX_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= i_cell.vld;
        end
        if (i_en) begin
            r_cell.flat  <= n_cell.flat;
            r_cell.rem   <= n_cell.rem;
            r_cell.den   <= n_cell.den;
            r_cell.quo   <= n_cell.quo;
            r_cell.col_a <= n_cell.col_a;
            r_cell.col_b <= n_cell.col_b;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== hw/rtl/plcr_blend.sv =====
module plcr_blend
    import plcr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [CHANNEL_BITS-1:0] i_a,
    input  logic [CHANNEL_BITS-1:0] i_b,
    input  logic [MIX_W-1:0]        i_mix,
    input  logic                    i_flat,
    output logic [CHANNEL_BITS-1:0] o_chan
);

    logic [CHANNEL_BITS+MIX_W:0] r_pa;
    logic [CHANNEL_BITS+MIX_W:0] r_pb;
    logic                        r_flat;
    logic [CHANNEL_BITS-1:0]     r_a;
    logic [CHANNEL_BITS+MIX_W+1:0] w_sum;

    // stage 1: two products, stage 2: sum and round half up
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa   <= (CHANNEL_BITS+MIX_W+1)'(i_a * ({1'b0, ~i_mix} + 17'd1));
            r_pb   <= (CHANNEL_BITS+MIX_W+1)'(i_b * i_mix);
            r_flat <= i_flat;
            r_a    <= i_a;
        end
    end

    assign w_sum = {1'b0, r_pa} + {1'b0, r_pb} + (CHANNEL_BITS+MIX_W+2)'(32768);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_chan <= r_flat ? r_a : w_sum[CHANNEL_BITS+MIX_W-1:MIX_W];
        end
    end

endmodule
